// File: rtl/pcs_pkg.sv
// Package for the packed counter store: item types, status codes, register
// indexes and the control structs passed between the store's modules.
// No dependencies.
package pcs_pkg;

    localparam int MAX_VALUE_DEF   = 1023;
    localparam int STORE_BYTES_DEF = 1025;
    localparam int BYTE_BITS       = 8;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_COUNTER = 2'd1;

    typedef struct packed {
        logic       req_type;
        logic [9:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] count;
        logic [1:0] status;
    } result_t;

    // Decoded request held while the store words are read.
    typedef struct packed {
        logic       add;
        logic       oor;
        logic       odd;
        logic [2:0] rem;
        logic [3:0] k;
    } slot_t;

    // Write-back of the two bytes that hold one counter.
    typedef struct packed {
        logic       hi_we;
        logic       lo_we;
        logic [7:0] hi_data;
        logic [7:0] lo_data;
    } wr_t;

endpackage

// File: rtl/pcs_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pcs_update.sv
// Counter extract, saturating increment and byte merge for one request.
// Depends on pcs_pkg.
module pcs_update (
    input  pcs_pkg::slot_t   slot,
    input  logic [7:0]       hi_byte,
    input  logic [7:0]       lo_byte,
    output pcs_pkg::wr_t     wr,
    output pcs_pkg::result_t res
);
    import pcs_pkg::*;

    logic [15:0] window;
    logic [15:0] shifted;
    logic [15:0] merged;
    logic [8:0]  full_w;
    logic [7:0]  full;
    logic [3:0]  shift;
    logic [7:0]  cnt;
    logic [7:0]  inc;
    logic        sat;
    logic        straddle;
    logic        do_write;

    always_comb
    begin
        window   = {hi_byte, lo_byte};
        full_w   = (9'd1 << slot.k) - 9'd1;
        full     = full_w[7:0];
        shift    = 4'(5'd16 - 5'(slot.rem) - 5'(slot.k));
        shifted  = window >> shift;
        cnt      = shifted[7:0] & full;
        sat      = (cnt == full);
        inc      = cnt + 8'd1;
        merged   = (window & ~(16'(full) << shift)) | (16'(inc) << shift);
        straddle = (5'(slot.rem) + 5'(slot.k)) > 5'(BYTE_BITS);
        do_write = slot.add && !slot.oor && !sat;

        wr.hi_we   = do_write;
        wr.lo_we   = do_write && straddle;
        wr.hi_data = merged[15:8];
        wr.lo_data = merged[7:0];

        if (slot.oor)
        begin
            res.count  = 8'd0;
            res.status = STATUS_RANGE;
        end
        else if (slot.add && sat)
        begin
            res.count  = cnt;
            res.status = STATUS_FULL;
        end
        else
        begin
            res.count  = slot.add ? inc : cnt;
            res.status = STATUS_OK;
        end
    end

endmodule

// File: rtl/packed_counter_store_unit.sv
// Top level of the packed counter store: request decode, control sequencer,
// configuration registers and the even and odd byte banks.
// Depends on pcs_pkg, pcs_ram and pcs_update.
//
//   Channel  Handshake            Payload
//   request  start / busy         req (req_type, value)
//   result   done (one cycle)     result (count, status)
//   config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item takes two steps: the byte banks are read on accept, then ST_EXEC
// merges and writes back; the next item may start with the result strobe.
// Even and odd bytes sit in separate single-port banks so that a counter
// crossing a byte boundary is read and written in one access each.
// After reset the banks are cleared one word a cycle, with busy high.
// The receiver cannot stall results.
module packed_counter_store_unit #(
    parameter int MAX_VALUE   = pcs_pkg::MAX_VALUE_DEF,
    parameter int STORE_BYTES = pcs_pkg::STORE_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  pcs_pkg::req_t                        req,
    output logic                                 done,
    output pcs_pkg::result_t                     result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pcs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [9:0]                           cfg_data
);
    import pcs_pkg::*;

    localparam int DEPTH_E    = (STORE_BYTES + 1) / 2;
    localparam int DEPTH_O    = STORE_BYTES / 2;
    localparam int AW_E       = (DEPTH_E > 1) ? $clog2(DEPTH_E) : 1;
    localparam int AW_O       = (DEPTH_O > 1) ? $clog2(DEPTH_O) : 1;
    localparam int STORE_BITS = STORE_BYTES * BYTE_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t      state_reg;
    logic [AW_E-1:0] clr_reg;
    logic [AW_E-1:0] e_addr_reg;
    logic [AW_O-1:0] o_addr_reg;
    slot_t       slot_reg;
    slot_t       slot_next;
    logic        done_reg;
    result_t     result_reg;
    logic [9:0]  max_value_reg;
    logic [3:0]  bpc_reg;

    logic [3:0]  k_eff;
    logic [13:0] start_bit;
    logic [10:0] byte0;
    logic [AW_E-1:0] e_addr_next;
    logic [AW_O-1:0] o_addr_next;
    logic        accept;

    logic [AW_E-1:0] e_addr;
    logic [AW_O-1:0] o_addr;
    logic        e_we;
    logic        o_we;
    logic [7:0]  e_wdata;
    logic [7:0]  o_wdata;
    logic [7:0]  e_rdata;
    logic [7:0]  o_rdata;
    logic [7:0]  hi_byte;
    logic [7:0]  lo_byte;
    wr_t         wr;
    result_t     upd_res;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        if (bpc_reg == 4'd0)
        begin
            k_eff = 4'd1;
        end
        else if (bpc_reg > 4'd8)
        begin
            k_eff = 4'd8;
        end
        else
        begin
            k_eff = bpc_reg;
        end
        start_bit     = 14'(req.value) * 14'(k_eff);
        byte0         = start_bit[13:3];
        o_addr_next   = AW_O'(byte0 >> 1);
        e_addr_next   = AW_E'((byte0 + 11'd1) >> 1);
        slot_next.add = req.req_type;
        slot_next.oor = (req.value > max_value_reg) || (32'(req.value) > MAX_VALUE)
                        || ((32'(start_bit) + 32'(k_eff)) > STORE_BITS);
        slot_next.odd = byte0[0];
        slot_next.rem = start_bit[2:0];
        slot_next.k   = k_eff;
    end

    assign hi_byte = slot_reg.odd ? o_rdata : e_rdata;
    assign lo_byte = slot_reg.odd ? e_rdata : o_rdata;

    pcs_update u_update (
        .slot    (slot_reg),
        .hi_byte (hi_byte),
        .lo_byte (lo_byte),
        .wr      (wr),
        .res     (upd_res)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_CLEAR:
            begin
                e_addr  = clr_reg;
                o_addr  = AW_O'(clr_reg);
                e_we    = 1'b1;
                o_we    = 32'(clr_reg) < DEPTH_O;
                e_wdata = 8'd0;
                o_wdata = 8'd0;
            end
            ST_EXEC:
            begin
                e_addr  = e_addr_reg;
                o_addr  = o_addr_reg;
                e_we    = slot_reg.odd ? wr.lo_we : wr.hi_we;
                o_we    = slot_reg.odd ? wr.hi_we : wr.lo_we;
                e_wdata = slot_reg.odd ? wr.lo_data : wr.hi_data;
                o_wdata = slot_reg.odd ? wr.hi_data : wr.lo_data;
            end
            default:
            begin
                e_addr  = e_addr_next;
                o_addr  = o_addr_next;
                e_we    = 1'b0;
                o_we    = 1'b0;
                e_wdata = 8'd0;
                o_wdata = 8'd0;
            end
        endcase
    end

    pcs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH_E),
        .AW    (AW_E)
    ) u_bank_even (
        .clk   (clk),
        .we    (e_we),
        .addr  (e_addr),
        .wdata (e_wdata),
        .rdata (e_rdata)
    );

    pcs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH_O),
        .AW    (AW_O)
    ) u_bank_odd (
        .clk   (clk),
        .we    (o_we),
        .addr  (o_addr),
        .wdata (o_wdata),
        .rdata (o_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            e_addr_reg    <= '0;
            o_addr_reg    <= '0;
            slot_reg      <= '0;
            result_reg    <= '0;
            done_reg      <= 1'b0;
            max_value_reg <= 10'd1023;
            bpc_reg       <= 4'd8;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_MAX_VALUE:        max_value_reg <= cfg_data;
                    REG_BITS_PER_COUNTER: bpc_reg       <= cfg_data[3:0];
                    default:              ;
                endcase
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + AW_E'(1);
                    if (32'(clr_reg) == DEPTH_E - 1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        slot_reg   <= slot_next;
                        e_addr_reg <= e_addr_next;
                        o_addr_reg <= o_addr_next;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    result_reg <= upd_res;
                    done_reg   <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/pcs_checker.sv
// Port-level checks for the packed counter store, bound to the top level.
// Depends on pcs_pkg and packed_counter_store_unit.
module pcs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input pcs_pkg::result_t result
);
    import pcs_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing two cycles after accept");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == STATUS_RANGE) |-> (result.count == 8'd0))
        else $error("out-of-range result with nonzero count");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == STATUS_OK || result.status == STATUS_RANGE
                  || result.status == STATUS_FULL))
        else $error("undefined status code");

endmodule

bind packed_counter_store_unit pcs_checker u_pcs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
